// File: src/stepper_axis_step_scheduler_top_macros.svh
// Assertion macros for the stepper axis step scheduler.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef STEPPER_AXIS_STEP_SCHEDULER_TOP_MACROS_SVH
`define STEPPER_AXIS_STEP_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SAS_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define SAS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/sas_pkg.sv
// Shared types and constants of the stepper axis step scheduler.
// No dependencies; the design modules import this package.
`timescale 1ns / 1ps
`default_nettype none

package sas_pkg;

  // Field widths
  localparam int OP_W       = 3;
  localparam int AXIS_W     = 2;
  localparam int POS_W      = 32;
  localparam int SPEED_W    = 16;
  localparam int STEPS_W    = 16;
  localparam int INTERVAL_W = 10;
  localparam int MASK_W     = 2;
  localparam int CFG_IDX_W  = 1;

  localparam int AXIS_COUNT_DEFAULT = 2;

  // Interval numerator (ms per second) and reset values
  localparam int INTERVAL_NUM        = 1000;
  localparam int MAX_SPEED_RESET     = 1000;
  localparam int DEFAULT_SPEED_RESET = 100;
  localparam int INTERVAL_RESET      = INTERVAL_NUM / DEFAULT_SPEED_RESET;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_MOVE_ABS = 3'd1,
    OP_MOVE_REL = 3'd2,
    OP_HOME     = 3'd3,
    OP_HOME_ALL = 3'd4,
    OP_STOP     = 3'd5,
    OP_ESTOP    = 3'd6,
    OP_CLEAR    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_MOVING = 2'd1,
    MODE_ERROR  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SPEED     = 1'b0,
    CFG_DEFAULT_SPEED = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TGT_ABS  = 2'd0,
    TGT_REL  = 2'd1,
    TGT_ZERO = 2'd2
  } tgt_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TICK,
    ST_ESTOP,
    ST_MV_PREP,
    ST_MV_DIFF,
    ST_MV_DIV,
    ST_MV_WRITE,
    ST_SEL,
    ST_CAPTURE
  } state_t;

  typedef struct packed {
    op_t                      operation;
    logic [AXIS_W-1:0]        axis;
    logic signed [POS_W-1:0]  position_or_steps;
    logic [SPEED_W-1:0]       speed;
  } req_t;

  typedef struct packed {
    logic                     result_code;
    logic [MASK_W-1:0]        step_mask;
    logic [MASK_W-1:0]        direction_mask;
    logic [1:0]               axis_status;
    logic signed [POS_W-1:0]  current_position;
    logic signed [POS_W-1:0]  target_position;
    logic [STEPS_W-1:0]       steps_left;
    logic [SPEED_W-1:0]       move_speed;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic     latch;
    logic     cur_inc;
    logic     cur_axis;
    logic     tick_axis;
    logic     estop_axis;
    logic     stop_axis;
    logic     clear_axis;
    logic     set_fail;
    logic     mv_prep;
    tgt_sel_t tgt_sel;
    logic     use_default;
    logic     mv_diff;
    logic     mv_write;
    logic     capture;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic axis_ok;
    logic cur_last;
    logic mv_ok;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: src/sas_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload types come from sas_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sas_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: src/stepper_axis_step_scheduler_top.sv
// Top level of the stepper axis step scheduler: controller plus datapath.
// Depends on sas_pkg, sas_stream_if, sas_ctrl and sas_datapath.
//
//   channel   dir   handshake              payload
//   command   in    valid/ready            operation, axis, position_or_steps, speed
//   report    out   valid/ready            result_code .. move_speed
//   cfg       in    cfg_write (no ready)   cfg_index, cfg_data
//
// One request at a time. A tick steps each axis in turn, an emergency stop halts
// each axis in turn; a stop, clear or move on an invalid axis fails.
// A move goes through the bit-serial interval divider before it is committed;
// home all does the same for each axis in turn.
// Reset is synchronous; all axes come up idle at position zero.
// A stalled report holds the controller in its capture step; the next request
// is taken as soon as the result register is loaded.
`timescale 1ns / 1ps
`default_nettype none

module stepper_axis_step_scheduler_top #(
  parameter int AXIS_COUNT = sas_pkg::AXIS_COUNT_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  sas_stream_if.sink                        command,
  sas_stream_if.source                      report,
  input  logic                              cfg_write,
  input  logic [sas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sas_pkg::SPEED_W-1:0]       cfg_data
);
  import sas_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic ready;

  assign command.ready = ready;

  sas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (command.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sas_datapath #(
    .AXIS_COUNT (AXIS_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (command.payload),
    .report    (report),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// File: src/sas_divider.sv
// Restoring divider for the step interval: 1000 / divisor, one quotient bit per cycle.
// Depends on sas_pkg for widths and the numerator.
`timescale 1ns / 1ps
`default_nettype none

module sas_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [sas_pkg::SPEED_W-1:0]       divisor,
  output logic                              busy,
  output logic [sas_pkg::INTERVAL_W-1:0]    quotient
);
  import sas_pkg::*;

  localparam int CW = $clog2(INTERVAL_W + 1);

  logic [INTERVAL_W-1:0] dvd;
  logic [INTERVAL_W-1:0] rem;
  logic [INTERVAL_W-1:0] q;
  logic [SPEED_W-1:0]    dsr;
  logic                  zero;
  logic [CW-1:0]         cnt;
  logic [INTERVAL_W:0]   trial;
  logic [INTERVAL_W:0]   trial_sub;
  logic                  fits;

  // Shift in the next numerator bit and try the subtraction
  assign trial     = {rem, dvd[INTERVAL_W-1]};
  assign fits      = {{(SPEED_W-INTERVAL_W-1){1'b0}}, trial} >= dsr;
  assign trial_sub = trial - dsr[INTERVAL_W:0];

  // A zero speed gives a zero interval
  assign quotient = zero ? '0 : q;

  // Control: load on start, count down one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(INTERVAL_W);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= INTERVAL_W'(INTERVAL_NUM);
      rem  <= '0;
      q    <= '0;
      dsr  <= divisor;
      zero <= (divisor == '0);
    end else if (busy) begin
      dvd <= {dvd[INTERVAL_W-2:0], 1'b0};
      rem <= fits ? trial_sub[INTERVAL_W-1:0] : trial[INTERVAL_W-1:0];
      q   <= {q[INTERVAL_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: src/sas_datapath.sv
// Datapath of the step scheduler: per-axis state, millisecond counter, config
// registers, interval divider and result register. Depends on sas_pkg,
// sas_stream_if and sas_divider.
`timescale 1ns / 1ps
`default_nettype none

module sas_datapath #(
  parameter int AXIS_COUNT = sas_pkg::AXIS_COUNT_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sas_pkg::req_t                     req,
  sas_stream_if.source                      report,
  input  logic                              cfg_write,
  input  logic [sas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sas_pkg::SPEED_W-1:0]       cfg_data,
  input  sas_pkg::cmd_t                     cmd,
  output sas_pkg::sts_t                     sts
);
  import sas_pkg::*;

  localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  // Configuration
  logic [SPEED_W-1:0] max_speed;
  logic [SPEED_W-1:0] default_speed;

  // Per-axis state
  mode_t                 mode     [AXIS_COUNT];
  logic [POS_W-1:0]      position [AXIS_COUNT];
  logic [POS_W-1:0]      target   [AXIS_COUNT];
  logic [SPEED_W-1:0]    speed    [AXIS_COUNT];
  logic                  dir      [AXIS_COUNT];
  logic [STEPS_W-1:0]    steps    [AXIS_COUNT];
  logic [INTERVAL_W-1:0] interval [AXIS_COUNT];
  logic [POS_W-1:0]      last     [AXIS_COUNT];
  logic [POS_W-1:0]      now_ms;

  // Latched request and work registers
  op_t                op_r;
  logic [AXIS_W-1:0]  axis_r;
  logic [POS_W-1:0]   pos_r;
  logic [SPEED_W-1:0] spd_r;
  logic [AXIS_W-1:0]  cur;
  logic               rc;
  logic [MASK_W-1:0]  smask;
  logic [POS_W-1:0]   tgt;
  logic [SPEED_W-1:0] mv_spd;
  logic               mv_ok;
  logic [POS_W-1:0]   diff;
  logic               dir_new;
  logic               rsp_valid;
  rsp_t               rsp;

  logic [AW-1:0]         ci;
  logic [POS_W-1:0]      elapsed;
  logic                  step_due;
  logic [SPEED_W-1:0]    spd_sel;
  logic [STEPS_W-1:0]    steps_abs;
  logic [MASK_W-1:0]     dmask;
  logic                  axis_ok;
  logic                  div_busy;
  logic [INTERVAL_W-1:0] quotient;

  assign ci      = cur[AW-1:0];
  assign axis_ok = ({1'b0, axis_r} < (AXIS_W+1)'(AXIS_COUNT));

  // Tick timing for the axis under the cursor
  assign elapsed  = now_ms - last[ci];
  assign step_due = elapsed >= {{(POS_W-INTERVAL_W){1'b0}}, interval[ci]};

  // Move speed and step count
  assign spd_sel   = cmd.use_default ? default_speed : spd_r;
  assign steps_abs = diff[POS_W-1] ? (STEPS_W'(0) - diff[STEPS_W-1:0]) : diff[STEPS_W-1:0];

  // Direction bits of the first two axes
  for (genvar g = 0; g < MASK_W; g++) begin : g_dmask
    if (g < AXIS_COUNT) begin : g_on
      assign dmask[g] = dir[g];
    end else begin : g_off
      assign dmask[g] = 1'b0;
    end
  end

  sas_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mv_diff),
    .divisor  (mv_spd),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Status to controller
  assign sts.op       = op_r;
  assign sts.axis_ok  = axis_ok;
  assign sts.cur_last = (cur == AXIS_W'(AXIS_COUNT - 1));
  assign sts.mv_ok    = mv_ok;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !rsp_valid || report.ready;

  assign report.valid   = rsp_valid;
  assign report.payload = rsp;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed     <= SPEED_W'(MAX_SPEED_RESET);
      default_speed <= SPEED_W'(DEFAULT_SPEED_RESET);
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_SPEED:     max_speed     <= cfg_data;
        CFG_DEFAULT_SPEED: default_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  // Update per-axis state and the millisecond counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        mode[i]     <= MODE_IDLE;
        position[i] <= '0;
        target[i]   <= '0;
        speed[i]    <= SPEED_W'(DEFAULT_SPEED_RESET);
        dir[i]      <= 1'b1;
        steps[i]    <= '0;
        interval[i] <= INTERVAL_W'(INTERVAL_RESET);
        last[i]     <= '0;
      end
      now_ms <= '0;
    end else begin
      if (cmd.latch && req.operation == OP_TICK) begin
        now_ms <= now_ms + POS_W'(1);
      end
      // Step a moving axis once its interval has run out; idle it when no steps remain
      if (cmd.tick_axis && mode[ci] == MODE_MOVING) begin
        if (steps[ci] != '0) begin
          if (step_due) begin
            last[ci]     <= now_ms;
            position[ci] <= dir[ci] ? position[ci] + POS_W'(1) : position[ci] - POS_W'(1);
            steps[ci]    <= steps[ci] - STEPS_W'(1);
          end
        end else begin
          mode[ci] <= MODE_IDLE;
        end
      end
      if (cmd.stop_axis) begin
        steps[ci] <= '0;
        mode[ci]  <= MODE_IDLE;
      end
      if (cmd.estop_axis) begin
        steps[ci] <= '0;
        mode[ci]  <= MODE_ERROR;
      end
      if (cmd.clear_axis) begin
        mode[ci]     <= MODE_IDLE;
        position[ci] <= '0;
        target[ci]   <= '0;
        steps[ci]    <= '0;
      end
      // Commit an accepted move
      if (cmd.mv_write) begin
        target[ci]   <= tgt;
        speed[ci]    <= mv_spd;
        interval[ci] <= quotient;
        steps[ci]    <= steps_abs;
        last[ci]     <= now_ms;
        dir[ci]      <= dir_new;
        mode[ci]     <= MODE_MOVING;
      end
    end
  end

  // Hold the request and the running result flags
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= req.operation;
      axis_r <= req.axis;
      pos_r  <= req.position_or_steps;
      spd_r  <= req.speed;
      rc     <= 1'b0;
      smask  <= '0;
      if (req.operation == OP_TICK || req.operation == OP_HOME_ALL ||
          req.operation == OP_ESTOP) begin
        cur <= '0;
      end else begin
        cur <= req.axis;
      end
    end else begin
      if (cmd.cur_inc) begin
        cur <= cur + AXIS_W'(1);
      end
      if (cmd.cur_axis) begin
        cur <= axis_r;
      end
      if (cmd.set_fail) begin
        rc <= 1'b1;
      end
      if (cmd.tick_axis && mode[ci] == MODE_MOVING && steps[ci] != '0 && step_due &&
          cur < AXIS_W'(MASK_W)) begin
        smask[cur[0]] <= 1'b1;
      end
      // Pick target and speed, check the speed limit
      if (cmd.mv_prep) begin
        case (cmd.tgt_sel)
          TGT_ABS: tgt <= pos_r;
          TGT_REL: tgt <= position[ci] + pos_r;
          default: tgt <= '0;
        endcase
        mv_spd <= spd_sel;
        mv_ok  <= (spd_sel <= max_speed);
        if (spd_sel > max_speed) begin
          rc <= 1'b1;
        end
      end
      if (cmd.mv_diff) begin
        diff    <= tgt - position[ci];
        dir_new <= $signed(tgt) > $signed(position[ci]);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.capture) begin
      rsp_valid <= 1'b1;
    end else if (report.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rsp.result_code    <= rc;
      rsp.step_mask      <= smask;
      rsp.direction_mask <= dmask;
      if (axis_ok) begin
        rsp.axis_status      <= mode[ci];
        rsp.current_position <= position[ci];
        rsp.target_position  <= target[ci];
        rsp.steps_left       <= steps[ci];
        rsp.move_speed       <= speed[ci];
      end else begin
        rsp.axis_status      <= '0;
        rsp.current_position <= '0;
        rsp.target_position  <= '0;
        rsp.steps_left       <= '0;
        rsp.move_speed       <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/sas_ctrl.sv
// Controller of the step scheduler: sequences each request through the datapath.
// Depends on sas_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "stepper_axis_step_scheduler_top_macros.svh"

module sas_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sas_pkg::sts_t sts,
  output sas_pkg::cmd_t cmd
);
  import sas_pkg::*;

  state_t state;
  state_t state_next;
  logic   is_move;

  assign is_move  = (sts.op == OP_MOVE_ABS) || (sts.op == OP_MOVE_REL) || (sts.op == OP_HOME);
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.op)
          OP_TICK:     state_next = ST_TICK;
          OP_ESTOP:    state_next = ST_ESTOP;
          OP_HOME_ALL: state_next = ST_MV_PREP;
          default: begin
            if (is_move && sts.axis_ok) begin
              state_next = ST_MV_PREP;
            end else begin
              state_next = ST_SEL;
            end
          end
        endcase
      end
      ST_TICK, ST_ESTOP: begin
        if (sts.cur_last) begin
          state_next = ST_SEL;
        end
      end
      ST_MV_PREP: state_next = ST_MV_DIFF;
      ST_MV_DIFF: state_next = sts.mv_ok ? ST_MV_DIV : ST_SEL;
      ST_MV_DIV: begin
        if (!sts.div_busy) begin
          state_next = ST_MV_WRITE;
        end
      end
      ST_MV_WRITE: begin
        if (sts.op == OP_HOME_ALL && !sts.cur_last) begin
          state_next = ST_MV_PREP;
        end else begin
          state_next = ST_SEL;
        end
      end
      ST_SEL: state_next = ST_CAPTURE;
      ST_CAPTURE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.tgt_sel = TGT_ZERO;
    case (state)
      ST_IDLE: cmd.latch = in_valid;
      ST_DECODE: begin
        case (sts.op)
          OP_STOP: begin
            cmd.stop_axis = sts.axis_ok;
            cmd.set_fail  = !sts.axis_ok;
          end
          OP_CLEAR: begin
            cmd.clear_axis = sts.axis_ok;
            cmd.set_fail   = !sts.axis_ok;
          end
          OP_MOVE_ABS, OP_MOVE_REL, OP_HOME: cmd.set_fail = !sts.axis_ok;
          default: ;
        endcase
      end
      ST_TICK: begin
        cmd.tick_axis = 1'b1;
        cmd.cur_inc   = !sts.cur_last;
      end
      ST_ESTOP: begin
        cmd.estop_axis = 1'b1;
        cmd.cur_inc    = !sts.cur_last;
      end
      ST_MV_PREP: begin
        cmd.mv_prep = 1'b1;
        case (sts.op)
          OP_MOVE_ABS: cmd.tgt_sel = TGT_ABS;
          OP_MOVE_REL: cmd.tgt_sel = TGT_REL;
          default: begin
            cmd.tgt_sel     = TGT_ZERO;
            cmd.use_default = 1'b1;
          end
        endcase
      end
      ST_MV_DIFF: cmd.mv_diff = sts.mv_ok;
      ST_MV_WRITE: begin
        cmd.mv_write = 1'b1;
        cmd.cur_inc  = (sts.op == OP_HOME_ALL) && !sts.cur_last;
      end
      ST_SEL: cmd.cur_axis = 1'b1;
      ST_CAPTURE: cmd.capture = sts.out_free;
      default: ;
    endcase
  end

  `SAS_IMPLIES(a_capture_free, cmd.capture, sts.out_free, "result captured over a pending one")
  `SAS_IMPLIES(a_write_after_div, cmd.mv_write, !sts.div_busy, "move committed before divide done")
  `SAS_NEXT(a_accept_decode, in_valid && in_ready, state == ST_DECODE, "accepted request not decoded")
  `SAS_NEXT(a_div_start_busy, cmd.mv_diff, sts.div_busy, "divider did not start")

endmodule

`default_nettype wire
